### hw/rtl/hpe_pkg.sv
// Shared types and constants for the haptic pulse envelope block.
`default_nettype none

package hpe_pkg;

   // Field widths
   localparam int INTEN_W  = 12;
   localparam int TIME_W   = 16;
   localparam int DUTY_W   = 16;
   localparam int QUOT_W   = 16;
   // 100 * 65535 fits in 23 bits
   localparam int WEIGHT_W = 23;

   // Request kinds
   localparam logic REQ_PULSE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // Envelope ratios, as exact integer fractions
   localparam int WT_TOTAL  = 35;
   localparam int WT_LEFT   = 65;
   localparam int PCT_SCALE = 100;
   localparam int DROP_NUM  = 7;
   localparam int DROP_DEN  = 10;

   localparam logic [DUTY_W-1:0] FS_RESET = 16'd1023;

   // Duty unit status seen by the control
   typedef struct packed {
      logic busy;
      logic done;
   } hpe_stat_type;

endpackage

`default_nettype wire

### hw/rtl/hpe_req_if.sv
// Request channel: pulse requests and time ticks.
`default_nettype none

interface hpe_req_if import hpe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [INTEN_W-1:0] intensity;
   logic [TIME_W-1:0]  duration;
   logic [TIME_W-1:0]  elapsed;

   modport source (output valid, req_type, intensity, duration, elapsed, input ready);
   modport sink   (input valid, req_type, intensity, duration, elapsed, output ready);
endinterface

`default_nettype wire

### hw/rtl/hpe_rsp_if.sv
// Response channel: PWM compare values.
`default_nettype none

interface hpe_rsp_if import hpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_level;

   modport source (output valid, duty_level, input ready);
   modport sink   (input valid, duty_level, output ready);
endinterface

`default_nettype wire

### hw/rtl/hpe_csr_if.sv
// Register write channel for the duty full-scale value.
`default_nettype none

interface hpe_csr_if import hpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/hpe_duty.sv
// Duty computation: two multiply steps, then a 16-step restoring divider.
`default_nettype none

module hpe_duty import hpe_pkg::*; #(
   parameter int FRAC_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DUTY_W-1:0]      full_scale,
   input  wire logic [FRAC_BITS:0]     level,
   input  wire logic [TIME_W-1:0]      time_left,
   input  wire logic [TIME_W-1:0]      time_total,
   output hpe_stat_type                stat,
   output logic      [QUOT_W-1:0]      quot
);

   localparam int LVL_W = FRAC_BITS + 1;
   localparam int P1_W  = DUTY_W + LVL_W;
   localparam int NUM_W = P1_W + WEIGHT_W;
   localparam int CNT_W = $clog2(QUOT_W);

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_MUL  = 4'b0010,
      U_PROD = 4'b0100,
      U_DIV  = 4'b1000
   } ustate_type;

   ustate_type           state_ff, state_in;
   logic [P1_W-1:0]      p1_ff, p1_in;
   logic [WEIGHT_W-1:0]  w_ff, w_in;
   logic [WEIGHT_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     div_ff, div_in;
   logic [QUOT_W-1:0]    q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 ge;

   assign ge = (rem_ff >= div_ff);

   always_comb begin
      state_in = state_ff;
      p1_in    = p1_ff;
      w_in     = w_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            p1_in = P1_W'(full_scale) * P1_W'(level);
            // zero total never happens; ratio taken as 35/100 if it did
            if (time_total == '0) begin
               w_in   = WEIGHT_W'(WT_TOTAL);
               den_in = WEIGHT_W'(PCT_SCALE);
            end else begin
               w_in   = WEIGHT_W'(time_total) * WEIGHT_W'(WT_TOTAL)
                      + WEIGHT_W'(time_left) * WEIGHT_W'(WT_LEFT);
               den_in = WEIGHT_W'(time_total) * WEIGHT_W'(PCT_SCALE);
            end
            state_in = U_PROD;
         end
         U_PROD: begin
            rem_in   = NUM_W'(p1_ff) * NUM_W'(w_ff);
            div_in   = NUM_W'({den_ff, {(FRAC_BITS + QUOT_W - 1){1'b0}}});
            q_in     = '0;
            cnt_in   = CNT_W'(QUOT_W - 1);
            state_in = U_DIV;
         end
         U_DIV: begin
            if (ge) begin
               rem_in = rem_ff - div_ff;
            end
            q_in   = {q_ff[QUOT_W-2:0], ge};
            div_in = div_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      w_ff   <= w_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = (state_ff != U_IDLE);
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

`default_nettype wire

### hw/rtl/haptic_pulse_envelope_top.sv
// Top level of the haptic pulse envelope generator.
`default_nettype none

// Rumble-motor envelope generator. Pulse requests (req_type 0) load an
// intensity (Q(INTEN_W-FRAC_BITS).FRAC_BITS, clamped to 1.0) and a duration; a
// request with zero intensity or zero duration is ignored, and while a pulse
// is playing a request below 0.7 of the current level is dropped. A tick
// (req_type 1) counts the remaining time down by elapsed, saturating at 0, and
// returns one transfer on rsp_if with duty_level =
// floor(full_scale * level * (35*total + 65*left) / (100 * total * 2^FRAC_BITS)),
// or 0 if no pulse was left. A pulse request updates the envelope registers
// at its transfer. A tick on a playing pulse runs two multiply steps, then a
// 16-step restoring divider that settles one quotient bit per cycle, then two
// hand-offs (divider done into the hold state, hold state into the output
// register once that is free). A tick on an idle envelope goes straight to
// the hold state. req_if is not ready while a tick is being computed or while
// its result waits for the output register. The output register holds a
// finished result until rsp_if takes it, so a new request can be taken
// meanwhile. duty_full_scale is written over csr_if, always ready; it resets
// to 1023 and should only be changed while the block is idle.

module haptic_pulse_envelope_top import hpe_pkg::*; #(
   parameter int FRAC_BITS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   hpe_req_if.sink   req_if,
   hpe_rsp_if.source rsp_if,
   hpe_csr_if.sink   csr_if
);

   localparam int LVL_W = FRAC_BITS + 1;
   // width wide enough for both the raw intensity and 1.0
   localparam int CMP_W = (LVL_W > INTEN_W) ? LVL_W : INTEN_W;
   localparam int WK_W  = CMP_W + 4;
   localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [DUTY_W-1:0]  full_scale_ff, full_scale_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [TIME_W-1:0]  time_left_ff, time_left_in;
   logic [TIME_W-1:0]  time_total_ff, time_total_in;
   logic               zero_ff, zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;

   logic               req_take;
   logic               out_free;
   logic               start;
   logic [CMP_W-1:0]   inten_ext;
   logic [CMP_W-1:0]   clamped;
   logic               too_faint;
   hpe_stat_type       stat;
   logic [QUOT_W-1:0]  quot;

   // ---- handshakes ----
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   // ---- pulse request qualification ----
   assign inten_ext = CMP_W'(req_if.intensity);
   assign clamped   = (inten_ext > ONE_C) ? ONE_C : inten_ext;
   // weaker than 0.7 of the current level: 10*intensity < 7*level
   assign too_faint = (WK_W'(clamped) * WK_W'(DROP_DEN)) < (WK_W'(level_ff) * WK_W'(DROP_NUM));

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      time_left_in  = time_left_ff;
      time_total_in = time_total_ff;
      zero_in       = zero_ff;
      rsp_valid_in  = rsp_valid_ff;
      duty_in       = duty_ff;
      full_scale_in = full_scale_ff;
      start         = 1'b0;

      if (csr_if.valid && csr_if.ready) begin
         full_scale_in = csr_if.wdata;
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_if.req_type == REQ_PULSE) begin
                  if (req_if.intensity != '0 && req_if.duration != '0
                      && !(time_left_ff != '0 && too_faint)) begin
                     level_in      = clamped[LVL_W-1:0];
                     time_left_in  = req_if.duration;
                     time_total_in = req_if.duration;
                  end
               end else if (time_left_ff == '0) begin
                  // idle tick: nothing playing, result is 0
                  zero_in  = 1'b1;
                  state_in = S_HOLD;
               end else begin
                  time_left_in = (req_if.elapsed >= time_left_ff) ? '0
                                 : time_left_ff - req_if.elapsed;
                  zero_in  = 1'b0;
                  start    = 1'b1;
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            if (stat.done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // wait for the output register to free up
            if (out_free) begin
               duty_in      = zero_ff ? '0 : quot;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         full_scale_ff <= FS_RESET;
         level_ff      <= '0;
         time_left_ff  <= '0;
         time_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         full_scale_ff <= full_scale_in;
         level_ff      <= level_in;
         time_left_ff  <= time_left_in;
         time_total_ff <= time_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      duty_ff <= duty_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.duty_level = duty_ff;

   // ---- shared multiply / divide unit ----
   // envelope state stays put while the unit runs: no request is taken then
   hpe_duty #(
      .FRAC_BITS (FRAC_BITS)
   ) u_duty (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .full_scale (full_scale_ff),
      .level      (level_ff),
      .time_left  (time_left_ff),
      .time_total (time_total_ff),
      .stat       (stat),
      .quot       (quot)
   );

`ifndef SYNTHESIS
   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !stat.busy)
      else $error("request ready while duty unit busy");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == S_CALC))
      else $error("duty unit finished outside of a tick computation");

   a_envelope_sane: assert property (@(posedge clock) disable iff (reset)
      (time_left_ff != '0) |-> (time_total_ff != '0 && time_left_ff <= time_total_ff
                                && level_ff <= ONE_C[LVL_W-1:0]))
      else $error("envelope state out of range");
`endif

endmodule

`default_nettype wire
